// File: hw/rtl/btia_pkg.sv
// Shared types, codes and sizes of the bus target with ID arbitration.
package btia_pkg;

    // Default sizes
    localparam int RING_DEPTH_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MID_DEPTH       = 4;
    localparam int OUT_DEPTH       = 4;

    // Field widths
    localparam int FUNC_W      = 2;
    localparam int ADDR_W      = 7;
    localparam int COUNT_W     = 5;
    localparam int CMD_W       = 8;
    localparam int ID_W        = 48;
    localparam int PADDR_W     = 8;
    localparam int LEN_W       = 3;
    localparam int DATA_W      = 56;
    localparam int AVG_REPLY_W = 32;
    localparam int ID_BYTES    = ID_W / 8;
    localparam int CFG_IDX_W   = 1;

    // Bus function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

    // Fixed addresses
    localparam logic [ADDR_W-1:0] GC_ADDRESS  = 7'd0;
    localparam logic [ADDR_W-1:0] ARB_ADDRESS = 7'd8;

    // General-call commands
    localparam logic [CMD_W-1:0] GC_RESTART  = 8'h00;
    localparam logic [CMD_W-1:0] GC_ANSWER   = 8'h01;
    localparam logic [CMD_W-1:0] GC_SET_ADDR = 8'h02;
    localparam logic [CMD_W-1:0] GC_LOAD_CMP = 8'h03;
    localparam logic [CMD_W-1:0] GC_LED_OFF  = 8'h04;
    localparam logic [CMD_W-1:0] GC_LED_ON   = 8'h05;

    // Own-address commands
    localparam logic [CMD_W-1:0] OWN_SEL_AVG  = 8'h00;
    localparam logic [CMD_W-1:0] OWN_SEL_ID   = 8'h01;
    localparam logic [CMD_W-1:0] OWN_LED_OFF  = 8'h02;
    localparam logic [CMD_W-1:0] OWN_LED_ON   = 8'h03;
    localparam logic [CMD_W-1:0] OWN_SEL_TEST = 8'h04;

    // Required write lengths
    localparam logic [COUNT_W-1:0] SET_ADDR_LEN = 5'd8;
    localparam logic [COUNT_W-1:0] LOAD_CMP_LEN = 5'd7;

    // Reply lengths and arbitration bytes
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ARB  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_AVG  = 3'd4;
    localparam logic [LEN_W-1:0] LEN_ID   = 3'd7;
    localparam logic [7:0]       ARB_WIN  = 8'h00;
    localparam logic [7:0]       ARB_LOSE = 8'hFF;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ADDR = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_SAMPLE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SEL_AVG  = 2'd0,
        SEL_ID   = 2'd1,
        SEL_TEST = 2'd2
    } readout_t;

    typedef struct packed {
        logic restart;
        logic answer_on;
        logic set_addr;
        logic load_cmp;
        logic led_off;
        logic led_on;
    } gc_act_t;

    typedef struct packed {
        logic sel_avg;
        logic sel_id;
        logic sel_test;
        logic led_off;
        logic led_on;
    } own_act_t;

    typedef struct packed {
        kind_t               kind;
        gc_act_t             gc;
        own_act_t            own;
        logic [ADDR_W-1:0]   bus_address;
        logic [ID_W-1:0]     payload_id;
        logic [ADDR_W-1:0]   new_address;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  read_len;
        logic [DATA_W-1:0] read_data;
        logic [ADDR_W-1:0] own_address;
        logic              address_store;
        logic              led_on;
        logic              restart_request;
        logic              answer_enabled;
        logic              avg_reply;
    } result_t;

endpackage

// File: hw/rtl/btia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/btia_fifo.sv
// Small flop-based FIFO with queue-style push/full and pop/empty.
module btia_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: hw/rtl/btia_front.sv
// Front end: accepts bus items and decodes them into actions.
module btia_front (
    input  logic                          push,
    output logic                          full,
    input  logic [btia_pkg::FUNC_W-1:0]   func,
    input  logic [btia_pkg::ADDR_W-1:0]   bus_address,
    input  logic [btia_pkg::COUNT_W-1:0]  byte_count,
    input  logic [btia_pkg::CMD_W-1:0]    command,
    input  logic [btia_pkg::ID_W-1:0]     payload_id,
    input  logic [btia_pkg::PADDR_W-1:0]  payload_address,
    input  logic                          mid_full,
    output logic                          mid_push,
    output btia_pkg::item_t               mid_item
);

    logic is_gc;

    assign full     = mid_full;
    assign mid_push = push && !mid_full;
    assign is_gc    = (bus_address == btia_pkg::GC_ADDRESS);

    always_comb
    begin
        // zero-length writes are decoded as KIND_NONE here
        priority if (func == btia_pkg::FUNC_WRITE && byte_count != '0)
        begin
            mid_item.kind = btia_pkg::KIND_WRITE;
        end
        else if (func == btia_pkg::FUNC_READ)
        begin
            mid_item.kind = btia_pkg::KIND_READ;
        end
        else if (func == btia_pkg::FUNC_SAMPLE)
        begin
            mid_item.kind = btia_pkg::KIND_SAMPLE;
        end
        else
        begin
            mid_item.kind = btia_pkg::KIND_NONE;
        end

        mid_item.gc.restart   = is_gc && (command == btia_pkg::GC_RESTART);
        mid_item.gc.answer_on = is_gc && (command == btia_pkg::GC_ANSWER);
        mid_item.gc.set_addr  = is_gc && (command == btia_pkg::GC_SET_ADDR)
                                && (byte_count == btia_pkg::SET_ADDR_LEN);
        mid_item.gc.load_cmp  = is_gc && (command == btia_pkg::GC_LOAD_CMP)
                                && (byte_count == btia_pkg::LOAD_CMP_LEN);
        mid_item.gc.led_off   = is_gc && (command == btia_pkg::GC_LED_OFF);
        mid_item.gc.led_on    = is_gc && (command == btia_pkg::GC_LED_ON);

        // own-address match is resolved in the back end
        mid_item.own.sel_avg  = (command == btia_pkg::OWN_SEL_AVG);
        mid_item.own.sel_id   = (command == btia_pkg::OWN_SEL_ID);
        mid_item.own.sel_test = (command == btia_pkg::OWN_SEL_TEST);
        mid_item.own.led_off  = (command == btia_pkg::OWN_LED_OFF);
        mid_item.own.led_on   = (command == btia_pkg::OWN_LED_ON);

        mid_item.bus_address  = bus_address;
        mid_item.payload_id   = payload_id;
        mid_item.new_address  = payload_address[btia_pkg::ADDR_W-1:0];
    end

endmodule

// File: hw/rtl/btia_back.sv
// Back end: device state, config registers, replies and the sample ring sum.
module btia_back #(
    parameter int SAMPLE_BITS = btia_pkg::SAMPLE_BITS_DEF,
    parameter int RING_DEPTH  = btia_pkg::RING_DEPTH_DEF,
    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            mid_empty,
    output logic                            mid_pop,
    input  btia_pkg::item_t                 mid_item,
    input  logic signed [SAMPLE_BITS-1:0]   mid_sample,
    input  logic                            cfg_valid,
    input  logic [btia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btia_pkg::ID_W-1:0]       cfg_data,
    output logic                            res_valid,
    output btia_pkg::result_t               res,
    output logic signed [SUM_W-1:0]         res_sum
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    logic [btia_pkg::ID_W-1:0]   device_id_reg, device_id_next;
    logic [btia_pkg::ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic [btia_pkg::ADDR_W-1:0] own_address_reg, own_address_next;
    logic                        answer_reg, answer_next;
    btia_pkg::readout_t          readout_reg, readout_next;
    logic [btia_pkg::ID_W-1:0]   compare_id_reg, compare_id_next;
    logic                        led_reg, led_next;
    logic                        restart_reg, restart_next;
    logic [IDX_W-1:0]            ring_index_reg, ring_index_next;
    logic [RING_DEPTH-1:0]       ring_vld_reg, ring_vld_next;
    logic                        rd_vld_reg;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;

    logic                          do_item;
    logic                          own_hit;
    logic                          do_sample;
    logic [IDX_W-1:0]              idx_inc;
    logic [IDX_W-1:0]              rd_addr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic [btia_pkg::DATA_W-1:0]   id_reply;
    logic                          store;

    assign do_item   = en && !mid_empty;
    assign mid_pop   = do_item;
    assign own_hit   = (mid_item.bus_address == own_address_reg);
    assign do_sample = do_item && (mid_item.kind == btia_pkg::KIND_SAMPLE);

    // ring index advances before the slot is replaced
    assign idx_inc         = (ring_index_reg == IDX_LAST) ? '0 : ring_index_reg + 1'b1;
    assign ring_index_next = do_sample ? idx_inc : ring_index_reg;
    // prefetch the slot the next sample will replace
    assign rd_addr         = (ring_index_next == IDX_LAST) ? '0 : ring_index_next + 1'b1;
    assign old_sample      = rd_vld_reg ? ram_rdata : '0;

    btia_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (do_sample),
        .waddr (idx_inc),
        .wdata (mid_sample),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ring_vld_next = ring_vld_reg;
        sum_next      = sum_reg;
        if (do_sample)
        begin
            ring_vld_next[idx_inc] = 1'b1;
            sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(mid_sample);
        end
    end

    // identity bytes go out most significant first, then the LED level
    always_comb
    begin
        id_reply = '0;
        for (int k = 0; k < btia_pkg::ID_BYTES; k++)
        begin
            id_reply[8*k +: 8] = device_id_reg[btia_pkg::ID_W-8-8*k +: 8];
        end
        id_reply[btia_pkg::ID_W] = led_reg;
    end

    always_comb
    begin
        device_id_next   = device_id_reg;
        init_addr_next   = init_addr_reg;
        own_address_next = own_address_reg;
        answer_next      = answer_reg;
        readout_next     = readout_reg;
        compare_id_next  = compare_id_reg;
        led_next         = led_reg;
        restart_next     = restart_reg;
        store            = 1'b0;

        if (do_item && mid_item.kind == btia_pkg::KIND_WRITE)
        begin
            if (mid_item.gc.restart)
            begin
                restart_next = 1'b1;
            end
            if (mid_item.gc.answer_on)
            begin
                answer_next = 1'b1;
            end
            if (mid_item.gc.set_addr && mid_item.payload_id == device_id_reg)
            begin
                answer_next      = 1'b0;
                own_address_next = mid_item.new_address;
                store            = 1'b1;
            end
            if (mid_item.gc.load_cmp)
            begin
                compare_id_next = mid_item.payload_id;
            end
            if (mid_item.gc.led_off)
            begin
                led_next = 1'b0;
            end
            if (mid_item.gc.led_on)
            begin
                led_next = 1'b1;
            end
            // own-address match uses the address from before this write
            if (own_hit)
            begin
                if (mid_item.own.sel_avg)
                begin
                    readout_next = btia_pkg::SEL_AVG;
                end
                if (mid_item.own.sel_id)
                begin
                    readout_next = btia_pkg::SEL_ID;
                end
                if (mid_item.own.sel_test)
                begin
                    readout_next = btia_pkg::SEL_TEST;
                end
                if (mid_item.own.led_off)
                begin
                    led_next = 1'b0;
                end
                if (mid_item.own.led_on)
                begin
                    led_next = 1'b1;
                end
            end
        end

        // config writes must arrive only while idle; the block itself does not enforce it
        if (cfg_valid)
        begin
            unique case (cfg_index)
                btia_pkg::CFG_DEVICE_ID:
                begin
                    device_id_next = cfg_data;
                end
                btia_pkg::CFG_INIT_ADDR:
                begin
                    init_addr_next   = cfg_data[btia_pkg::ADDR_W-1:0];
                    own_address_next = cfg_data[btia_pkg::ADDR_W-1:0];
                end
                default:
                begin
                    device_id_next = device_id_reg;
                end
            endcase
        end
    end

    // reply and status, state after the step
    always_comb
    begin
        res.read_len        = btia_pkg::LEN_NONE;
        res.read_data       = '0;
        res.avg_reply       = 1'b0;
        res.own_address     = own_address_next;
        res.address_store   = store;
        res.led_on          = led_next;
        res.restart_request = restart_next;
        res.answer_enabled  = answer_next;

        if (mid_item.kind == btia_pkg::KIND_READ)
        begin
            priority if (mid_item.bus_address == btia_pkg::ARB_ADDRESS && answer_reg)
            begin
                res.read_len       = btia_pkg::LEN_ARB;
                res.read_data[7:0] = (device_id_reg <= compare_id_reg) ?
                                     btia_pkg::ARB_WIN : btia_pkg::ARB_LOSE;
            end
            else if (own_hit)
            begin
                unique case (readout_reg)
                    btia_pkg::SEL_AVG:
                    begin
                        // bytes filled in once the average is known
                        res.read_len  = btia_pkg::LEN_AVG;
                        res.avg_reply = 1'b1;
                    end
                    btia_pkg::SEL_ID:
                    begin
                        res.read_len  = btia_pkg::LEN_ID;
                        res.read_data = id_reply;
                    end
                    default:
                    begin
                        res.read_len = btia_pkg::LEN_NONE;
                    end
                endcase
            end
            else
            begin
                res.read_len = btia_pkg::LEN_NONE;
            end
        end
    end

    assign res_valid = do_item;
    assign res_sum   = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg   <= '0;
            init_addr_reg   <= '0;
            own_address_reg <= '0;
            answer_reg      <= 1'b0;
            readout_reg     <= btia_pkg::SEL_AVG;
            compare_id_reg  <= '0;
            led_reg         <= 1'b0;
            restart_reg     <= 1'b0;
            ring_index_reg  <= '0;
            ring_vld_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            sum_reg         <= '0;
        end
        else
        begin
            device_id_reg   <= device_id_next;
            init_addr_reg   <= init_addr_next;
            own_address_reg <= own_address_next;
            answer_reg      <= answer_next;
            readout_reg     <= readout_next;
            compare_id_reg  <= compare_id_next;
            led_reg         <= led_next;
            restart_reg     <= restart_next;
            ring_index_reg  <= ring_index_next;
            ring_vld_reg    <= ring_vld_next;
            rd_vld_reg      <= ring_vld_reg[rd_addr];
            sum_reg         <= sum_next;
        end
    end

endmodule

// File: hw/rtl/btia_avg_pipe.sv
// Average stage: divides the ring sum by the depth with a constant reciprocal multiply.
module btia_avg_pipe #(
    parameter int SAMPLE_BITS = btia_pkg::SAMPLE_BITS_DEF,
    parameter int RING_DEPTH  = btia_pkg::RING_DEPTH_DEF,
    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  btia_pkg::result_t             in_res,
    input  logic signed [SUM_W-1:0]       in_sum,
    output logic                          out_valid,
    output btia_pkg::result_t             out_res,
    output logic signed [SAMPLE_BITS-1:0] out_avg
);

    // floor(x / RING_DEPTH) == (x * RECIP) >> SHIFT for every x below 2**SUM_W;
    // for a power-of-two depth RECIP is a single bit and the multiply is a shift
    localparam int SHIFT   = SUM_W + $clog2(RING_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // stage A: sum as it left the state stage
    logic                          a_vld_reg;
    btia_pkg::result_t             a_res_reg;
    logic signed [SUM_W-1:0]       a_sum_reg;

    // stage B: quotient magnitude and sign
    logic                          b_vld_reg;
    btia_pkg::result_t             b_res_reg;
    logic                          b_neg_reg;
    logic [SAMPLE_BITS-1:0]        b_quo_reg;

    logic                          out_valid_reg;
    btia_pkg::result_t             out_res_reg;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;

    logic [SUM_W-1:0]                        mag;
    logic [PROD_W-1:0]                       prod;
    logic [SAMPLE_BITS-1:0]                  quo;
    logic signed [SAMPLE_BITS-1:0]           avg_c;
    logic signed [btia_pkg::AVG_REPLY_W-1:0] avg_ext;
    btia_pkg::result_t                       res_c;

    // magnitude divide; truncation toward zero falls out of the sign fix
    assign mag   = a_sum_reg[SUM_W-1] ? (~a_sum_reg + 1'b1) : a_sum_reg;
    assign prod  = PROD_W'(mag) * PROD_W'(RECIP);
    assign quo   = prod[SHIFT +: SAMPLE_BITS];

    assign avg_c   = b_neg_reg ? (~b_quo_reg + 1'b1) : b_quo_reg;
    assign avg_ext = btia_pkg::AVG_REPLY_W'(avg_c);

    // average readout: sign-extended average, low byte first
    always_comb
    begin
        res_c = b_res_reg;
        if (b_res_reg.avg_reply)
        begin
            res_c.read_data = {
                (btia_pkg::DATA_W - btia_pkg::AVG_REPLY_W)'(0), avg_ext};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            out_valid_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_res_reg   <= in_res;
            a_sum_reg   <= in_sum;
            b_res_reg   <= a_res_reg;
            b_neg_reg   <= a_sum_reg[SUM_W-1];
            b_quo_reg   <= quo;
            out_res_reg <= res_c;
            out_avg_reg <= avg_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_avg   = out_avg_reg;

endmodule

// File: hw/rtl/bus_target_with_id_arbitration_core.sv
// Top level of the bus target with ID arbitration.
//
// Input channel: queue style. An item (bus write, bus read or sensor sample)
// transfers on a clock edge with push high and full low. The front end
// decodes it into a short queue, so full only rises when that queue backs up.
// Result channel: queue style. The oldest result is on the ports while empty
// is low and transfers on an edge with pop high. Every item gives one result.
// Config channel: cfg_valid/cfg_ready, always ready; index 0 is device_id,
// index 1 is initial_address (also loads the own address at once). Write it
// only while no item is in flight.
// Throughput: one item per cycle while pop keeps the output queue from filling.
// Path from an input transfer to empty going low: the middle queue, the
// state stage, the reciprocal-multiply divide stage, then the output register
// that fixes the sign and fills the average reply, then the output queue.
// Stall: if pop stays low the output queue fills, the back end and divider
// freeze, then the middle queue fills and full rises. Nothing is dropped.
// Reset (rst_n low, async): queues empty, state cleared, ring reads as zero,
// own address and both config registers zero.
module bus_target_with_id_arbitration_core #(
    parameter int RING_DEPTH  = btia_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = btia_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            push,
    output logic                            full,
    input  logic [btia_pkg::FUNC_W-1:0]     func,
    input  logic [btia_pkg::ADDR_W-1:0]     bus_address,
    input  logic [btia_pkg::COUNT_W-1:0]    byte_count,
    input  logic [btia_pkg::CMD_W-1:0]      command,
    input  logic [btia_pkg::ID_W-1:0]       payload_id,
    input  logic [btia_pkg::PADDR_W-1:0]    payload_address,
    input  logic signed [SAMPLE_BITS-1:0]   sample,

    output logic                            empty,
    input  logic                            pop,
    output logic [btia_pkg::LEN_W-1:0]      read_len,
    output logic [btia_pkg::DATA_W-1:0]     read_data,
    output logic [btia_pkg::ADDR_W-1:0]     own_address_out,
    output logic                            address_store,
    output logic                            led_on,
    output logic                            restart_request,
    output logic                            answer_enabled,
    output logic signed [SAMPLE_BITS-1:0]   average_out,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [btia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btia_pkg::ID_W-1:0]       cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH);
    localparam int MID_W = $bits(btia_pkg::item_t) + SAMPLE_BITS;
    localparam int OUT_W = $bits(btia_pkg::result_t) + SAMPLE_BITS;

    // front -> middle queue
    logic                          mid_push;
    logic                          mid_full;
    btia_pkg::item_t               front_item;
    logic [MID_W-1:0]              mid_dout;
    logic                          mid_empty;
    logic                          mid_pop;
    btia_pkg::item_t               mid_item;
    logic signed [SAMPLE_BITS-1:0] mid_sample;

    // back -> divider -> output queue
    logic                          pipe_en;
    logic                          back_valid;
    btia_pkg::result_t             back_res;
    logic signed [SUM_W-1:0]       back_sum;
    logic                          pipe_valid;
    btia_pkg::result_t             pipe_res;
    logic signed [SAMPLE_BITS-1:0] pipe_avg;
    logic                          out_full;
    logic [OUT_W-1:0]              out_dout;
    btia_pkg::result_t             out_res;

    assign cfg_ready = 1'b1;

    btia_front u_front (
        .push            (push),
        .full            (full),
        .func            (func),
        .bus_address     (bus_address),
        .byte_count      (byte_count),
        .command         (command),
        .payload_id      (payload_id),
        .payload_address (payload_address),
        .mid_full        (mid_full),
        .mid_push        (mid_push),
        .mid_item        (front_item)
    );

    btia_fifo #(
        .WIDTH (MID_W),
        .DEPTH (btia_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   ({front_item, sample}),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign {mid_item, mid_sample} = mid_dout;

    // whole back end moves only when the output queue has room
    assign pipe_en = !out_full;

    btia_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .mid_empty  (mid_empty),
        .mid_pop    (mid_pop),
        .mid_item   (mid_item),
        .mid_sample (mid_sample),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (back_valid),
        .res        (back_res),
        .res_sum    (back_sum)
    );

    btia_avg_pipe #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (back_valid),
        .in_res    (back_res),
        .in_sum    (back_sum),
        .out_valid (pipe_valid),
        .out_res   (pipe_res),
        .out_avg   (pipe_avg)
    );

    btia_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (btia_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pipe_valid && pipe_en),
        .din   ({pipe_res, pipe_avg}),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign {out_res, average_out} = out_dout;

    assign read_len        = out_res.read_len;
    assign read_data       = out_res.read_data;
    assign own_address_out = out_res.own_address;
    assign address_store   = out_res.address_store;
    assign led_on          = out_res.led_on;
    assign restart_request = out_res.restart_request;
    assign answer_enabled  = out_res.answer_enabled;

endmodule
